// ===== rtl/aesd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 decryption package
// S-box tables, GF(2^8) helpers and shared types for the decrypt pipeline.
// ----------------------------------------------------------------------------
package aesd_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int KEY_CFG_INDEX_W = 1;
  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW = 1'b1;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic last;
  } side_t;

  function automatic logic [7:0] fwd_sbox(input logic [7:0] a);
    logic [7:0] t [0:255];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [0:255];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte k of a block sits in bits 127-8k down to 120-8k.
  function automatic logic [7:0] get_byte(input block_t b, input int k);
    return b[127 - 8 * k -: 8];
  endfunction

endpackage

// ===== rtl/aesd_key_expand.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 key expansion
// Produces the round keys one round per cycle after a key register write.
// ----------------------------------------------------------------------------
module aesd_key_expand (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  aesd_pkg::block_t                         key,
  output logic                                     busy,
  output aesd_pkg::block_t [aesd_pkg::NUM_ROUNDS:0] round_keys
);

  localparam aesd_pkg::block_t ZERO_KEY_EXP [0:aesd_pkg::NUM_ROUNDS] = '{
    128'h00000000000000000000000000000000, 128'h62636363626363636263636362636363,
    128'h9b9898c9f9fbfbaa9b9898c9f9fbfbaa, 128'h90973450696ccffaf2f457330b0fac99,
    128'hee06da7b876a1581759e42b27e91ee2b, 128'h7f2e2b88f8443e098dda7cbbf34b9290,
    128'hec614b851425758c99ff09376ab49ba7, 128'h217517873550620bacaf6b3cc61bf09b,
    128'h0ef903333ba9613897060a04511dfa9f, 128'hb1d4d8e28a7db9da1d7bb3de4c664941,
    128'hb4ef5bcb3e92e21123e951cf6f8f188e
  };

  logic [3:0] step;
  logic [7:0] rcon;
  aesd_pkg::block_t prev;
  aesd_pkg::block_t next_key;
  logic [31:0] w0, w1, w2, w3, rot;

  always_comb begin
    prev = round_keys[step];
    rot = {aesd_pkg::fwd_sbox(prev[23:16]), aesd_pkg::fwd_sbox(prev[15:8]),
           aesd_pkg::fwd_sbox(prev[7:0]), aesd_pkg::fwd_sbox(prev[31:24])};
    w0 = prev[127:96] ^ rot ^ {rcon, 24'h0};
    w1 = prev[95:64] ^ w0;
    w2 = prev[63:32] ^ w1;
    w3 = prev[31:0] ^ w2;
    next_key = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      rcon <= 8'h01;
      for (int r = 0; r <= aesd_pkg::NUM_ROUNDS; r++) round_keys[r] <= ZERO_KEY_EXP[r];
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      rcon <= 8'h01;
      round_keys[0] <= key;
    end else if (busy) begin
      round_keys[step + 4'd1] <= next_key;
      rcon <= aesd_pkg::xtime(rcon);
      step <= step + 4'd1;
      if (step == 4'(aesd_pkg::NUM_ROUNDS - 1)) busy <= 1'b0;
    end
  end

endmodule

// ===== rtl/aesd_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES inverse round stage
// One registered inverse round: shift rows, substitution, key add, mix (mix only when DO_MIX is set).
// ----------------------------------------------------------------------------
module aesd_round #(
  parameter bit DO_MIX = 1'b1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  aesd_pkg::side_t  in_side,
  input  aesd_pkg::block_t in_state,
  input  aesd_pkg::block_t round_key,
  output logic             out_valid,
  output aesd_pkg::side_t  out_side,
  output aesd_pkg::block_t out_state
);

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = '0;
    x = a;
    for (int k = 0; k < 4; k++) begin
      if (b[k]) acc = acc ^ x;
      x = aesd_pkg::xtime(x);
    end
    return acc;
  endfunction

  aesd_pkg::block_t subbed, keyed, mixed;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        subbed[127 - 8 * (c * 4 + r) -: 8] =
          aesd_pkg::inv_sbox(aesd_pkg::get_byte(in_state, ((c - r + 4) % 4) * 4 + r));
      end
    end
    keyed = subbed ^ round_key;
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3;
      a0 = aesd_pkg::get_byte(keyed, c * 4);
      a1 = aesd_pkg::get_byte(keyed, c * 4 + 1);
      a2 = aesd_pkg::get_byte(keyed, c * 4 + 2);
      a3 = aesd_pkg::get_byte(keyed, c * 4 + 3);
      mixed[127 - 32 * c -: 8] = gmul(a0, 4'he) ^ gmul(a1, 4'hb) ^ gmul(a2, 4'hd) ^ gmul(a3, 4'h9);
      mixed[119 - 32 * c -: 8] = gmul(a0, 4'h9) ^ gmul(a1, 4'he) ^ gmul(a2, 4'hb) ^ gmul(a3, 4'hd);
      mixed[111 - 32 * c -: 8] = gmul(a0, 4'hd) ^ gmul(a1, 4'h9) ^ gmul(a2, 4'he) ^ gmul(a3, 4'hb);
      mixed[103 - 32 * c -: 8] = gmul(a0, 4'hb) ^ gmul(a1, 4'hd) ^ gmul(a2, 4'h9) ^ gmul(a3, 4'he);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_side <= in_side;
      out_state <= DO_MIX ? mixed : keyed;
    end
  end

endmodule

// ===== rtl/aes128_ecb_block_decrypt_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 ECB block decrypt unit
// Pipelined inverse cipher with on-chip key expansion and PKCS7 trim count.
// ----------------------------------------------------------------------------
// Usage: write key_high (index 0) and key_low (index 1) through the cfg port
// while no word is in flight. Each write restarts key expansion, one round
// key a cycle, and in_ready stays low after the write until the last round
// key is in place. Ciphertext words enter on the in channel (valid/ready)
// and plaintext words leave on the out channel in the same order. The
// pipeline has an input key-add stage, ten round stages and a trim stage,
// and one word is accepted every cycle unless the receiver stalls or key
// expansion is running. The whole pipeline advances together: when the
// receiver stalls with the last stage full, every stage holds, empty ones
// included, and in_ready drops, so nothing is lost or repeated. Reset
// clears all valid bits and loads the round keys of the all-zero key.
// ----------------------------------------------------------------------------
module aes128_ecb_block_decrypt_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [aesd_pkg::KEY_CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] cipher_high,
  input  logic [63:0] cipher_low,
  input  logic        last_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] plain_high,
  output logic [63:0] plain_low,
  output logic [4:0]  kept_bytes,
  output logic        is_last
);

  localparam int NR = aesd_pkg::NUM_ROUNDS;

  logic [63:0] key_high, key_low;
  logic        key_start;
  logic        key_busy;
  logic        key_hold;
  aesd_pkg::block_t [NR:0] round_keys;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      key_start <= 1'b0;
    end else begin
      key_start <= cfg_write;
      if (cfg_write) begin
        unique case (cfg_index)
          aesd_pkg::REG_KEY_HIGH: key_high <= cfg_data;
          aesd_pkg::REG_KEY_LOW:  key_low <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  aesd_key_expand u_keys (
    .clk(clk), .rst(rst), .start(key_start), .key({key_high, key_low}),
    .busy(key_busy), .round_keys(round_keys)
  );

  assign key_hold = key_start || key_busy;

  logic advance;
  assign advance = !out_valid || out_ready;
  assign in_ready = advance && !key_hold;

  logic             sv [0:NR];
  aesd_pkg::side_t  ss [0:NR];
  aesd_pkg::block_t st [0:NR];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (advance) begin
      sv[0] <= in_valid && !key_hold;
    end
    if (advance) begin
      ss[0].last <= last_block;
      st[0] <= {cipher_high, cipher_low} ^ round_keys[NR];
    end
  end

  for (genvar g = 1; g <= NR; g++) begin : g_round
    aesd_round #(.DO_MIX(g != NR)) u_round (
      .clk(clk), .rst(rst), .advance(advance),
      .in_valid(sv[g - 1]), .in_side(ss[g - 1]), .in_state(st[g - 1]),
      .round_key(round_keys[NR - g]),
      .out_valid(sv[g]), .out_side(ss[g]), .out_state(st[g])
    );
  end

  logic [7:0] final_byte;
  assign final_byte = st[NR][7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= sv[NR];
    end
    if (advance) begin
      plain_high <= st[NR][127:64];
      plain_low <= st[NR][63:0];
      is_last <= ss[NR].last;
      if (ss[NR].last && final_byte >= 8'd1 && final_byte <= 8'd16) begin
        kept_bytes <= 5'd16 - final_byte[4:0];
      end else begin
        kept_bytes <= 5'd16;
      end
    end
  end

endmodule
